### rtl/gtm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtm_pkg
// Types, codes, tables and constants shared by the gamepad-to-touch mapper.
// ----------------------------------------------------------------------------
package gtm_pkg;

    localparam int TABLE_LEN              = 11;
    localparam int MAPPED_BUTTONS_DEFAULT = 11;
    localparam int IDX_W                  = $clog2(TABLE_LEN);

    localparam int IN_DATA_W   = 80;
    localparam int OUT_DATA_W  = 24;
    localparam int OUT_USER_W  = 6;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Division by 25 * 32767: reciprocal estimate, then one correction step
    localparam int QUO_BITS    = 18;
    localparam int PROD_W      = 27;
    localparam int SCALE_W     = 10;
    localparam int RECIP_W     = 23;
    localparam int RECIP_SHIFT = 32;
    localparam int NUM_W       = PROD_W + SCALE_W;
    localparam int DEN_W       = 20;
    localparam int REM_W       = DEN_W + 1;
    localparam int OFF_W       = QUO_BITS + 1;

    localparam logic [DEN_W-1:0]   DIV_DEN    = 20'd819175;
    localparam logic [SCALE_W-1:0] MOVE_SCALE = 10'd768;
    localparam logic [SCALE_W-1:0] AIM_SCALE  = 10'd960;
    localparam logic [RECIP_W-1:0] RECIP_MOVE =
        RECIP_W'((64'(MOVE_SCALE) << RECIP_SHIFT) / 64'(DIV_DEN));
    localparam logic [RECIP_W-1:0] RECIP_AIM  =
        RECIP_W'((64'(AIM_SCALE) << RECIP_SHIFT) / 64'(DIV_DEN));

    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [15:0] AIM_LO  = 16'd3277;
    localparam logic [15:0] AIM_HI  = 16'd62259;

    localparam logic [14:0] DEAD_ZONE_RST     = 15'd8000;
    localparam logic [11:0] MOVE_GAIN_RST     = 12'd256;
    localparam logic [11:0] AIM_GAIN_RST      = 12'd256;
    localparam logic [15:0] MOVE_CENTER_X_RST = 16'd16384;
    localparam logic [15:0] MOVE_CENTER_Y_RST = 16'd49152;
    localparam logic [15:0] AIM_CENTER_X_RST  = 16'd49152;
    localparam logic [15:0] AIM_CENTER_Y_RST  = 16'd32768;

    localparam logic [3:0] SLOT_MOVE        = 4'd0;
    localparam logic [3:0] SLOT_AIM         = 4'd1;
    localparam logic [3:0] SLOT_BUTTON_BASE = 4'd5;

    typedef enum logic [1:0] {
        ACT_PRESS   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_MOVE    = 2'd2
    } action_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEAD_ZONE     = 3'd0,
        CFG_MOVE_GAIN     = 3'd1,
        CFG_AIM_GAIN      = 3'd2,
        CFG_MOVE_CENTER_X = 3'd3,
        CFG_MOVE_CENTER_Y = 3'd4,
        CFG_AIM_CENTER_X  = 3'd5,
        CFG_AIM_CENTER_Y  = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_BUTTON,
        EV_MOVE_PRESS,
        EV_MOVE_MOVE,
        EV_MOVE_RELEASE,
        EV_AIM_PRESS,
        EV_AIM_MOVE
    } ev_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_WAIT_DIV,
        ST_LEFT,
        ST_RIGHT,
        ST_RIGHT_EV
    } ctrl_state_t;

    typedef enum logic [1:0] {
        LP_IDLE,
        LP_LOAD,
        LP_STEP,
        LP_FINAL
    } lane_phase_t;

    typedef struct packed {
        logic             capture;
        logic             div_start;
        ev_kind_t         ev;
        logic [IDX_W-1:0] btn_idx;
        logic             aim_update;
        logic             aim_recentre;
        logic             commit;
    } gtm_cmd_t;

    typedef struct packed {
        logic connected;
        logic btn_edge;
        logic defl_left;
        logic defl_right;
        logic move_active;
        logic aim_active;
        logic div_done;
        logic ev_free;
    } gtm_status_t;

    function automatic logic [15:0] btn_mask(input logic [IDX_W-1:0] idx);
        logic [15:0] m;
        unique case (idx)
            4'd0:    m = 16'h0001;
            4'd1:    m = 16'h0002;
            4'd2:    m = 16'h0004;
            4'd3:    m = 16'h0008;
            4'd4:    m = 16'h0010;
            4'd5:    m = 16'h0100;
            4'd6:    m = 16'h0200;
            4'd7:    m = 16'h1000;
            4'd8:    m = 16'h2000;
            4'd9:    m = 16'h4000;
            4'd10:   m = 16'h8000;
            default: m = 16'h0000;
        endcase
        return m;
    endfunction

    // x in the high half, y in the low half, Q0.16
    function automatic logic [31:0] btn_pos(input logic [IDX_W-1:0] idx);
        logic [31:0] p;
        unique case (idx)
            4'd0:    p = {16'd32768, 16'd9830};
            4'd1:    p = {16'd32768, 16'd55706};
            4'd2:    p = {16'd9830,  16'd32768};
            4'd3:    p = {16'd55706, 16'd32768};
            4'd4:    p = {16'd62259, 16'd3277};
            4'd5:    p = {16'd6554,  16'd36045};
            4'd6:    p = {16'd58982, 16'd22938};
            4'd7:    p = {16'd32768, 16'd55706};
            4'd8:    p = {16'd55706, 16'd32768};
            4'd9:    p = {16'd13107, 16'd45875};
            4'd10:   p = {16'd52429, 16'd13107};
            default: p = 32'd0;
        endcase
        return p;
    endfunction

endpackage

### rtl/gtm_div_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtm_div_lane
// Scales one stick axis by its gain and floor-divides it by the fixed
// denominator: a reciprocal estimate, a remainder and one correction step.
// ----------------------------------------------------------------------------
module gtm_div_lane
    import gtm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [15:0]      axis,
    input  logic        [11:0]      gain,
    input  logic                    aim_scale,
    input  logic                    negate,
    output logic                    done,
    output logic signed [OFF_W-1:0] offset
);

    lane_phase_t              phase_reg, phase_next;
    logic [PROD_W-1:0]        prod_reg;
    logic                     neg_reg;
    logic [QUO_BITS-1:0]      quo_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [REM_W-1:0]         rem_reg;
    logic signed [OFF_W-1:0]  off_reg;

    logic [15:0]               mag;
    logic [RECIP_W-1:0]        recip;
    logic [SCALE_W-1:0]        scale;
    logic [PROD_W+RECIP_W-1:0] est;
    logic [NUM_W-1:0]          back;
    logic [NUM_W-1:0]          diff;
    logic                      over;
    logic [QUO_BITS-1:0]       quo_fix;
    logic [REM_W-1:0]          rem_fix;
    logic [OFF_W-1:0]          mag_q;

    assign mag   = axis[15] ? (~axis + 16'd1) : axis;
    assign recip = aim_scale ? RECIP_AIM : RECIP_MOVE;
    assign scale = aim_scale ? AIM_SCALE : MOVE_SCALE;

    // estimate is exact or one short
    assign est  = {{RECIP_W{1'b0}}, prod_reg} * {{PROD_W{1'b0}}, recip};
    assign back = {{(NUM_W-QUO_BITS){1'b0}}, quo_reg} * {{(NUM_W-DEN_W){1'b0}}, DIV_DEN};
    assign diff = num_reg - back;

    assign over    = rem_reg >= {1'b0, DIV_DEN};
    assign quo_fix = quo_reg + {{(QUO_BITS-1){1'b0}}, over};
    assign rem_fix = over ? (rem_reg - {1'b0, DIV_DEN}) : rem_reg;
    assign mag_q   = {1'b0, quo_fix} + {{(OFF_W-1){1'b0}}, (rem_fix != '0)};

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            LP_IDLE:
            begin
                if (start)
                begin
                    phase_next = LP_LOAD;
                end
            end
            LP_LOAD:
            begin
                phase_next = LP_STEP;
            end
            LP_STEP:
            begin
                phase_next = LP_FINAL;
            end
            LP_FINAL:
            begin
                phase_next = LP_IDLE;
            end
            default:
            begin
                phase_next = LP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= LP_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == LP_IDLE && start)
        begin
            prod_reg <= PROD_W'(mag * gain);
            neg_reg  <= axis[15] ^ negate;
        end
        if (phase_reg == LP_LOAD)
        begin
            quo_reg <= est[RECIP_SHIFT +: QUO_BITS];
            num_reg <= {{(NUM_W-PROD_W){1'b0}}, prod_reg} * {{(NUM_W-SCALE_W){1'b0}}, scale};
        end
        if (phase_reg == LP_STEP)
        begin
            rem_reg <= diff[REM_W-1:0];
        end
        if (phase_reg == LP_FINAL)
        begin
            // round towards minus infinity on a negative quotient
            off_reg <= neg_reg ? -$signed(mag_q) : $signed({1'b0, quo_fix});
        end
    end

    assign done   = (phase_reg == LP_IDLE);
    assign offset = off_reg;

endmodule

### rtl/gtm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtm_datapath
// Configuration registers, poll capture, button edges, stick arithmetic,
// touch state and the two-stage result pipeline.
// ----------------------------------------------------------------------------
module gtm_datapath
    import gtm_pkg::*;
#(
    parameter int MAPPED_BUTTONS = MAPPED_BUTTONS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [IN_DATA_W-1:0]   in_tdata,
    input  logic                   in_connected,
    input  gtm_cmd_t               cmd,
    output gtm_status_t            status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_DATA_W-1:0]  out_tdata,
    output logic [OUT_USER_W-1:0]  out_tuser,
    output logic                   out_tlast
);

    localparam int SCAN_COUNT = (MAPPED_BUTTONS < TABLE_LEN) ? MAPPED_BUTTONS : TABLE_LEN;

    // configuration
    logic [14:0] dead_zone_reg;
    logic [11:0] move_gain_reg, aim_gain_reg;
    logic [15:0] move_cx_reg, move_cy_reg, aim_cx_reg, aim_cy_reg;

    // captured poll
    logic               conn_reg;
    logic [15:0]        btn_reg;
    logic signed [15:0] lx_reg, ly_reg, rx_reg, ry_reg;

    // touch state
    logic [15:0] prev_btn_reg;
    logic        move_active_reg, aim_active_reg;
    logic [15:0] aim_x_reg, aim_y_reg;

    // event stage and output stage
    logic        ev_valid_reg;
    logic [3:0]  ev_slot_reg;
    action_t     ev_action_reg;
    logic [16:0] ev_qx_reg, ev_qy_reg;
    logic        ev_last_reg;
    logic        out_valid_reg;
    logic [3:0]  out_slot_reg;
    action_t     out_action_reg;
    logic [9:0]  out_x_reg, out_y_reg;
    logic        out_last_reg;

    logic                    done_lx, done_ly, done_rx, done_ry;
    logic signed [OFF_W-1:0] off_lx, off_ly, off_rx, off_ry;

    logic [TABLE_LEN-1:0] edge_vec;
    logic                 higher_edge;
    logic                 defl_left, defl_right, has_left;
    logic                 out_load, ev_free;
    logic [31:0]          pos_sel;
    logic                 btn_now;
    logic signed [20:0]   sum_mx, sum_my, sum_ax, sum_ay;
    logic [16:0]          tgt_mx, tgt_my;
    logic [15:0]          acc_x, acc_y;

    logic [3:0]  ev_slot;
    action_t     ev_action;
    logic [16:0] ev_qx, ev_qy;
    logic        ev_last;

    function automatic logic [15:0] abs16(input logic signed [15:0] a);
        return a[15] ? (~a + 16'd1) : a;
    endfunction

    function automatic logic [16:0] clamp_move(input logic signed [20:0] v);
        logic [16:0] r;
        if (v < 21'sd0)
        begin
            r = '0;
        end
        else if (v > $signed({4'b0, ONE_Q16}))
        begin
            r = ONE_Q16;
        end
        else
        begin
            r = v[16:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] clamp_aim(input logic signed [20:0] v);
        logic [15:0] r;
        if (v < $signed({5'b0, AIM_LO}))
        begin
            r = AIM_LO;
        end
        else if (v > $signed({5'b0, AIM_HI}))
        begin
            r = AIM_HI;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic [9:0] thousandths(input logic [16:0] q);
        logic [26:0] p;
        p = 27'(q * 27'd1000) + 27'd32768;
        return p[25:16];
    endfunction

    function automatic logic signed [20:0] add_off(input logic [15:0] base,
                                                   input logic signed [OFF_W-1:0] off);
        return $signed({5'b0, base}) + $signed({{(21-OFF_W){off[OFF_W-1]}}, off});
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg <= DEAD_ZONE_RST;
            move_gain_reg <= MOVE_GAIN_RST;
            aim_gain_reg  <= AIM_GAIN_RST;
            move_cx_reg   <= MOVE_CENTER_X_RST;
            move_cy_reg   <= MOVE_CENTER_Y_RST;
            aim_cx_reg    <= AIM_CENTER_X_RST;
            aim_cy_reg    <= AIM_CENTER_Y_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEAD_ZONE:     dead_zone_reg <= cfg_data[14:0];
                CFG_MOVE_GAIN:     move_gain_reg <= cfg_data[11:0];
                CFG_AIM_GAIN:      aim_gain_reg  <= cfg_data[11:0];
                CFG_MOVE_CENTER_X: move_cx_reg   <= cfg_data;
                CFG_MOVE_CENTER_Y: move_cy_reg   <= cfg_data;
                CFG_AIM_CENTER_X:  aim_cx_reg    <= cfg_data;
                CFG_AIM_CENTER_Y:  aim_cy_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            conn_reg <= in_connected;
            btn_reg  <= in_tdata[15:0];
            lx_reg   <= in_tdata[31:16];
            ly_reg   <= in_tdata[47:32];
            rx_reg   <= in_tdata[63:48];
            ry_reg   <= in_tdata[79:64];
        end
    end

    gtm_div_lane u_lane_lx (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .axis(lx_reg),
        .gain(move_gain_reg), .aim_scale(1'b0), .negate(1'b0),
        .done(done_lx), .offset(off_lx)
    );

    gtm_div_lane u_lane_ly (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .axis(ly_reg),
        .gain(move_gain_reg), .aim_scale(1'b0), .negate(1'b1),
        .done(done_ly), .offset(off_ly)
    );

    gtm_div_lane u_lane_rx (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .axis(rx_reg),
        .gain(aim_gain_reg), .aim_scale(1'b1), .negate(1'b0),
        .done(done_rx), .offset(off_rx)
    );

    gtm_div_lane u_lane_ry (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .axis(ry_reg),
        .gain(aim_gain_reg), .aim_scale(1'b1), .negate(1'b1),
        .done(done_ry), .offset(off_ry)
    );

    assign defl_left  = (abs16(lx_reg) > {1'b0, dead_zone_reg})
                     || (abs16(ly_reg) > {1'b0, dead_zone_reg});
    assign defl_right = (abs16(rx_reg) > {1'b0, dead_zone_reg})
                     || (abs16(ry_reg) > {1'b0, dead_zone_reg});
    assign has_left   = defl_left || move_active_reg;

    always_comb
    begin
        for (int i = 0; i < TABLE_LEN; i++)
        begin
            edge_vec[i] = (i < SCAN_COUNT)
                       && (((btn_reg ^ prev_btn_reg) & btn_mask(IDX_W'(i))) != '0);
        end
        higher_edge = 1'b0;
        for (int i = 0; i < TABLE_LEN; i++)
        begin
            if (i > int'(cmd.btn_idx))
            begin
                higher_edge = higher_edge | edge_vec[i];
            end
        end
    end

    assign pos_sel = btn_pos(cmd.btn_idx);
    assign btn_now = (btn_reg & btn_mask(cmd.btn_idx)) != '0;

    assign sum_mx = add_off(move_cx_reg, off_lx);
    assign sum_my = add_off(move_cy_reg, off_ly);
    assign sum_ax = add_off(aim_x_reg, off_rx);
    assign sum_ay = add_off(aim_y_reg, off_ry);
    assign tgt_mx = clamp_move(sum_mx);
    assign tgt_my = clamp_move(sum_my);
    assign acc_x  = clamp_aim(sum_ax);
    assign acc_y  = clamp_aim(sum_ay);

    always_comb
    begin
        ev_slot   = SLOT_MOVE;
        ev_action = ACT_PRESS;
        ev_qx     = {1'b0, move_cx_reg};
        ev_qy     = {1'b0, move_cy_reg};
        ev_last   = 1'b0;
        unique case (cmd.ev)
            EV_BUTTON:
            begin
                ev_slot   = SLOT_BUTTON_BASE + {{(4-IDX_W){1'b0}}, cmd.btn_idx};
                ev_action = btn_now ? ACT_PRESS : ACT_RELEASE;
                ev_qx     = {1'b0, pos_sel[31:16]};
                ev_qy     = {1'b0, pos_sel[15:0]};
                ev_last   = !higher_edge && !has_left && !defl_right;
            end
            EV_MOVE_MOVE:
            begin
                ev_action = ACT_MOVE;
                ev_qx     = tgt_mx;
                ev_qy     = tgt_my;
                ev_last   = !defl_right;
            end
            EV_MOVE_RELEASE:
            begin
                ev_action = ACT_RELEASE;
                ev_last   = !defl_right;
            end
            EV_AIM_PRESS:
            begin
                ev_slot = SLOT_AIM;
                ev_qx   = {1'b0, aim_cx_reg};
                ev_qy   = {1'b0, aim_cy_reg};
            end
            EV_AIM_MOVE:
            begin
                ev_slot   = SLOT_AIM;
                ev_action = ACT_MOVE;
                ev_qx     = {1'b0, aim_x_reg};
                ev_qy     = {1'b0, aim_y_reg};
                ev_last   = 1'b1;
            end
            default:
            begin
                ev_slot = SLOT_MOVE;
            end
        endcase
    end

    // touch state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_btn_reg    <= '0;
            move_active_reg <= 1'b0;
            aim_active_reg  <= 1'b0;
            aim_x_reg       <= '0;
            aim_y_reg       <= '0;
        end
        else
        begin
            if (cmd.commit)
            begin
                prev_btn_reg <= btn_reg;
            end
            if (cmd.ev == EV_MOVE_PRESS)
            begin
                move_active_reg <= 1'b1;
            end
            else if (cmd.ev == EV_MOVE_RELEASE)
            begin
                move_active_reg <= 1'b0;
            end
            if (cmd.ev == EV_AIM_PRESS)
            begin
                aim_active_reg <= 1'b1;
            end
            else if (cmd.aim_recentre)
            begin
                aim_active_reg <= 1'b0;
            end
            if (cmd.aim_update)
            begin
                aim_x_reg <= acc_x;
                aim_y_reg <= acc_y;
            end
            else if (cmd.aim_recentre)
            begin
                aim_x_reg <= aim_cx_reg;
                aim_y_reg <= aim_cy_reg;
            end
        end
    end

    assign out_load = ev_valid_reg && (!out_valid_reg || out_ready);
    assign ev_free  = !ev_valid_reg || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ev != EV_NONE)
            begin
                ev_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                ev_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ev != EV_NONE)
        begin
            ev_slot_reg   <= ev_slot;
            ev_action_reg <= ev_action;
            ev_qx_reg     <= ev_qx;
            ev_qy_reg     <= ev_qy;
            ev_last_reg   <= ev_last;
        end
        if (out_load)
        begin
            out_slot_reg   <= ev_slot_reg;
            out_action_reg <= ev_action_reg;
            out_x_reg      <= thousandths(ev_qx_reg);
            out_y_reg      <= thousandths(ev_qy_reg);
            out_last_reg   <= ev_last_reg;
        end
    end

    assign status.connected   = conn_reg;
    assign status.btn_edge    = edge_vec[cmd.btn_idx];
    assign status.defl_left   = defl_left;
    assign status.defl_right  = defl_right;
    assign status.move_active = move_active_reg;
    assign status.aim_active  = aim_active_reg;
    assign status.div_done    = done_lx && done_ly && done_rx && done_ry;
    assign status.ev_free     = ev_free;

    assign out_valid = out_valid_reg;
    assign out_tdata = {4'b0000, out_y_reg, out_x_reg};
    assign out_tuser = {out_action_reg, out_slot_reg};
    assign out_tlast = out_last_reg;

endmodule

### rtl/gtm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtm_ctrl
// Sequencer for one poll: capture, button scan, movement touch, aim touch.
// ----------------------------------------------------------------------------
module gtm_ctrl
    import gtm_pkg::*;
#(
    parameter int MAPPED_BUTTONS = MAPPED_BUTTONS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  gtm_status_t status,
    output gtm_cmd_t    cmd
);

    localparam int SCAN_COUNT = (MAPPED_BUTTONS < TABLE_LEN) ? MAPPED_BUTTONS : TABLE_LEN;
    localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(SCAN_COUNT - 1);

    ctrl_state_t      state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        in_ready         = 1'b0;
        cmd.capture      = 1'b0;
        cmd.div_start    = 1'b0;
        cmd.ev           = EV_NONE;
        cmd.btn_idx      = idx_reg;
        cmd.aim_update   = 1'b0;
        cmd.aim_recentre = 1'b0;
        cmd.commit       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // drop a disconnected poll untouched
                if (!status.connected)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    idx_next      = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!status.btn_edge || status.ev_free)
                begin
                    if (status.btn_edge)
                    begin
                        cmd.ev = EV_BUTTON;
                    end
                    if (idx_reg == SCAN_LAST)
                    begin
                        state_next = ST_WAIT_DIV;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_WAIT_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_LEFT;
                end
            end
            ST_LEFT:
            begin
                if (status.defl_left)
                begin
                    if (status.ev_free)
                    begin
                        if (!status.move_active)
                        begin
                            cmd.ev = EV_MOVE_PRESS;
                        end
                        else
                        begin
                            cmd.ev     = EV_MOVE_MOVE;
                            state_next = ST_RIGHT;
                        end
                    end
                end
                else if (status.move_active)
                begin
                    if (status.ev_free)
                    begin
                        cmd.ev     = EV_MOVE_RELEASE;
                        state_next = ST_RIGHT;
                    end
                end
                else
                begin
                    state_next = ST_RIGHT;
                end
            end
            ST_RIGHT:
            begin
                if (status.defl_right)
                begin
                    cmd.aim_update = 1'b1;
                    state_next     = ST_RIGHT_EV;
                end
                else
                begin
                    cmd.aim_recentre = 1'b1;
                    cmd.commit       = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_RIGHT_EV:
            begin
                if (status.ev_free)
                begin
                    if (!status.aim_active)
                    begin
                        cmd.ev = EV_AIM_PRESS;
                    end
                    else
                    begin
                        cmd.ev     = EV_AIM_MOVE;
                        cmd.commit = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/gamepad_to_touch_mapper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_to_touch_mapper_unit
// Turns polled gamepad states into touch press, move and release items.
//
// Channel   Direction  Handshake                  Contents
// s_axis    in         s_axis_tvalid/tready       one gamepad poll
// m_axis    out        m_axis_tvalid/tready       one touch event, tlast ends poll
// cfg       in         cfg_valid/cfg_ready        register index and value
//
// A connected poll is captured and checked, then the button scan visits each
// mapped button, the dividers hand over their results, and the movement touch
// and then the aim touch follow. Four divider lanes run during the scan; the
// hand-over waits until all four are done. A disconnected poll is dropped after
// capture. Reset restores the register defaults and clears all touch state.
// A stalled output holds in a two-deep stage.
// ----------------------------------------------------------------------------
module gamepad_to_touch_mapper_unit
    import gtm_pkg::*;
#(
    parameter int MAPPED_BUTTONS = MAPPED_BUTTONS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // buttons[15:0], left_x[31:16], left_y[47:32], right_x[63:48], right_y[79:64]
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    // connected[0]
    input  logic [0:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // pos_x[9:0], pos_y[19:10], zero[23:20]
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    // touch_slot[3:0], action[5:4]
    output logic [OUT_USER_W-1:0]  m_axis_tuser,
    output logic                   m_axis_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    gtm_cmd_t    cmd;
    gtm_status_t status;

    assign cfg_ready = 1'b1;

    gtm_ctrl #(
        .MAPPED_BUTTONS(MAPPED_BUTTONS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    gtm_datapath #(
        .MAPPED_BUTTONS(MAPPED_BUTTONS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_tdata    (s_axis_tdata),
        .in_connected(s_axis_tuser[0]),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_tdata   (m_axis_tdata),
        .out_tuser   (m_axis_tuser),
        .out_tlast   (m_axis_tlast)
    );

endmodule

### rtl/gtm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtm_checker
// Port-level checks on the gamepad-to-touch mapper, bound to the top level.
// ----------------------------------------------------------------------------
module gtm_checker
    import gtm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser,
    input logic                  m_axis_tlast
);

    // hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled output item changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again before the poll was processed");

    a_slot_action: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[5:4] != 2'd3)
            && !(m_axis_tuser[3:0] == 4'd2 || m_axis_tuser[3:0] == 4'd3
                 || m_axis_tuser[3:0] == 4'd4))
        else $error("invalid slot or action code");

    a_move_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[5:4] == ACT_MOVE)
            |-> (m_axis_tuser[3:0] == SLOT_MOVE || m_axis_tuser[3:0] == SLOT_AIM))
        else $error("move event on a button slot");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[9:0] <= 10'd1000) && (m_axis_tdata[19:10] <= 10'd1000)
            && (m_axis_tdata[23:20] == 4'd0))
        else $error("touch position out of range");

endmodule

bind gamepad_to_touch_mapper_unit gtm_checker u_gtm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
);

### tb/sv/tb_gamepad_to_touch_mapper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gamepad_to_touch_mapper_unit
// Self-checking bench for the gamepad-to-touch mapper. Polls are offered on
// the input stream with random gaps, and a local predictor of the button scan,
// the movement stick and the aim accumulator queues the touch events each
// accepted poll should cause. Each event leaving the output stream is checked
// field by field. Registers are rewritten between phases, the extremes among
// them, and one phase holds the output off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_gamepad_to_touch_mapper_unit;
    import gtm_pkg::*;

    localparam int BUTTON_COUNT = 11;
    localparam longint FULL_SCALE = 65536;
    localparam longint AIM_MIN = 3277;
    localparam longint AIM_MAX = 62259;
    localparam longint MOVE_DEN = 25 * 32767;
    localparam longint AIM_DEN = 5 * 32767;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT = 3000;

    typedef struct packed {
        logic               connected;
        logic [15:0]        buttons;
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
    } poll_t;

    typedef struct packed {
        logic [3:0] slot;
        action_t    action;
        logic [9:0] px;
        logic [9:0] py;
        logic       last;
    } touch_event_t;

    typedef struct packed {
        logic [14:0] dz;
        logic [11:0] move_gain;
        logic [11:0] aim_gain;
        logic [15:0] move_cx;
        logic [15:0] move_cy;
        logic [15:0] aim_cx;
        logic [15:0] aim_cy;
    } setting_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic [0:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [OUT_USER_W-1:0]  m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    setting_t     live_cfg;
    logic [15:0]  prev_buttons;
    logic         move_on;
    logic         aim_on;
    logic [15:0]  aim_acc_x;
    logic [15:0]  aim_acc_y;
    touch_event_t poll_events [16];
    int           poll_count;
    touch_event_t touch_q [$];
    touch_event_t head_event;

    logic [15:0]        held_buttons = '0;
    logic signed [15:0] held_lx = '0;
    logic signed [15:0] held_ly = '0;
    logic signed [15:0] held_rx = '0;
    logic signed [15:0] held_ry = '0;

    bit no_gaps = 1'b0;
    int hold_request = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int failures = 0;
    int polls_sent = 0;
    int events_checked = 0;
    int reg_writes = 0;

    gamepad_to_touch_mapper_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] button_bit(input int i);
        case (i)
            0:       return 16'h0001;
            1:       return 16'h0002;
            2:       return 16'h0004;
            3:       return 16'h0008;
            4:       return 16'h0010;
            5:       return 16'h0100;
            6:       return 16'h0200;
            7:       return 16'h1000;
            8:       return 16'h2000;
            9:       return 16'h4000;
            default: return 16'h8000;
        endcase
    endfunction

    function automatic logic [31:0] button_spot(input int i);
        case (i)
            0:       return {16'd32768, 16'd9830};
            1:       return {16'd32768, 16'd55706};
            2:       return {16'd9830, 16'd32768};
            3:       return {16'd55706, 16'd32768};
            4:       return {16'd62259, 16'd3277};
            5:       return {16'd6554, 16'd36045};
            6:       return {16'd58982, 16'd22938};
            7:       return {16'd32768, 16'd55706};
            8:       return {16'd55706, 16'd32768};
            9:       return {16'd13107, 16'd45875};
            default: return {16'd52429, 16'd13107};
        endcase
    endfunction

    function automatic logic [9:0] thousandths(input longint q);
        longint t;
        t = (q * 1000 + 32768) >>> 16;
        return t[9:0];
    endfunction

    function automatic longint floor_quot(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic bit beyond_dead_zone(input logic signed [15:0] a,
                                            input logic signed [15:0] b);
        int aa;
        int bb;
        aa = (a < 0) ? -int'(a) : int'(a);
        bb = (b < 0) ? -int'(b) : int'(b);
        return aa > int'(live_cfg.dz) || bb > int'(live_cfg.dz);
    endfunction

    task automatic note_event(input logic [3:0] slot, input action_t act,
                              input longint qx, input longint qy);
        poll_events[poll_count] = '{slot, act, thousandths(qx), thousandths(qy), 1'b0};
        poll_count = poll_count + 1;
    endtask

    task automatic predict_touches(input poll_t p);
        longint ox;
        longint oy;
        logic   now_down;
        logic   was_down;
        poll_count = 0;
        if (!p.connected)
            return;
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            now_down = (p.buttons & button_bit(i)) != 0;
            was_down = (prev_buttons & button_bit(i)) != 0;
            if (now_down != was_down)
                note_event(SLOT_BUTTON_BASE + 4'(i), now_down ? ACT_PRESS : ACT_RELEASE,
                           longint'(button_spot(i) >> 16), longint'(button_spot(i) & 32'hFFFF));
        end
        if (beyond_dead_zone(p.lx, p.ly))
        begin
            ox = floor_quot(longint'(p.lx) * longint'(live_cfg.move_gain) * 768, MOVE_DEN);
            oy = floor_quot(-longint'(p.ly) * longint'(live_cfg.move_gain) * 768, MOVE_DEN);
            if (!move_on)
            begin
                note_event(SLOT_MOVE, ACT_PRESS, live_cfg.move_cx, live_cfg.move_cy);
                move_on = 1'b1;
            end
            note_event(SLOT_MOVE, ACT_MOVE,
                       clip(longint'(live_cfg.move_cx) + ox, 0, FULL_SCALE),
                       clip(longint'(live_cfg.move_cy) + oy, 0, FULL_SCALE));
        end
        else if (move_on)
        begin
            note_event(SLOT_MOVE, ACT_RELEASE, live_cfg.move_cx, live_cfg.move_cy);
            move_on = 1'b0;
        end
        if (beyond_dead_zone(p.rx, p.ry))
        begin
            ox = floor_quot(longint'(p.rx) * longint'(live_cfg.aim_gain) * 192, AIM_DEN);
            oy = floor_quot(-longint'(p.ry) * longint'(live_cfg.aim_gain) * 192, AIM_DEN);
            aim_acc_x = 16'(clip(longint'(aim_acc_x) + ox, AIM_MIN, AIM_MAX));
            aim_acc_y = 16'(clip(longint'(aim_acc_y) + oy, AIM_MIN, AIM_MAX));
            if (!aim_on)
            begin
                note_event(SLOT_AIM, ACT_PRESS, live_cfg.aim_cx, live_cfg.aim_cy);
                aim_on = 1'b1;
            end
            note_event(SLOT_AIM, ACT_MOVE, aim_acc_x, aim_acc_y);
        end
        else
        begin
            aim_on = 1'b0;
            aim_acc_x = live_cfg.aim_cx;
            aim_acc_y = live_cfg.aim_cy;
        end
        prev_buttons = p.buttons;
        if (poll_count > 0)
            poll_events[poll_count - 1].last = 1'b1;
        for (int i = 0; i < poll_count; i++)
            touch_q.push_back(poll_events[i]);
    endtask

    function automatic poll_t mk_poll(input logic c, input logic [15:0] b,
                                      input int lx, input int ly, input int rx, input int ry);
        return '{c, b, 16'(lx), 16'(ly), 16'(rx), 16'(ry)};
    endfunction

    function automatic setting_t mk_setting(input int dz, input int mg, input int ag,
                                            input int mcx, input int mcy,
                                            input int acx, input int acy);
        return '{15'(dz), 12'(mg), 12'(ag), 16'(mcx), 16'(mcy), 16'(acx), 16'(acy)};
    endfunction

    function automatic setting_t random_setting();
        return mk_setting($urandom_range(32767), $urandom_range(4095), $urandom_range(4095),
                          $urandom_range(65535), $urandom_range(65535),
                          $urandom_range(65535), $urandom_range(65535));
    endfunction

    function automatic logic signed [15:0] pick_axis(input logic signed [15:0] held);
        int d;
        int v;
        d = int'(live_cfg.dz);
        case ($urandom_range(9))
            0, 1, 2: v = held;
            3:       v = $urandom_range(1) ? 32767 : -32768;
            4:
            begin
                v = d + int'($urandom_range(1));
                if ($urandom_range(1))
                    v = -v;
                if (v > 32767)
                    v = 32767;
            end
            5:       v = int'($urandom_range(2 * d)) - d;
            6, 7:    v = int'($urandom_range(65535)) - 32768;
            default: v = 0;
        endcase
        return v[15:0];
    endfunction

    function automatic poll_t random_poll();
        poll_t p;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: p.buttons = held_buttons ^ (16'h0001 << $urandom_range(15));
            6:                p.buttons = held_buttons;
            7, 8:             p.buttons = 16'($urandom_range(65535));
            default:          p.buttons = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        endcase
        p.connected = $urandom_range(99) < 92;
        p.lx = pick_axis(held_lx);
        p.ly = pick_axis(held_ly);
        p.rx = pick_axis(held_rx);
        p.ry = pick_axis(held_ry);
        held_buttons = p.buttons;
        held_lx = p.lx;
        held_ly = p.ly;
        held_rx = p.rx;
        held_ry = p.ry;
        return p;
    endfunction

    task automatic send_poll(input poll_t p);
        @(negedge clk);
        while (!no_gaps && $urandom_range(99) < 30)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {p.ry, p.rx, p.ly, p.lx, p.buttons};
        s_axis_tuser = p.connected;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_touches(p);
        polls_sent = polls_sent + 1;
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [15:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_DEAD_ZONE:     live_cfg.dz = value[14:0];
            CFG_MOVE_GAIN:     live_cfg.move_gain = value[11:0];
            CFG_AIM_GAIN:      live_cfg.aim_gain = value[11:0];
            CFG_MOVE_CENTER_X: live_cfg.move_cx = value;
            CFG_MOVE_CENTER_Y: live_cfg.move_cy = value;
            CFG_AIM_CENTER_X:  live_cfg.aim_cx = value;
            CFG_AIM_CENTER_Y:  live_cfg.aim_cy = value;
            default:           ;
        endcase
        reg_writes = reg_writes + 1;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic settle_block();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (touch_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_setting(input setting_t s);
        settle_block();
        write_register(CFG_DEAD_ZONE, 16'(s.dz));
        write_register(CFG_MOVE_GAIN, 16'(s.move_gain));
        write_register(CFG_AIM_GAIN, 16'(s.aim_gain));
        write_register(CFG_MOVE_CENTER_X, s.move_cx);
        write_register(CFG_MOVE_CENTER_Y, s.move_cy);
        write_register(CFG_AIM_CENTER_X, s.aim_cx);
        write_register(CFG_AIM_CENTER_Y, s.aim_cy);
    endtask

    task automatic test_directed_polls();
        send_poll(mk_poll(1, 16'h0000, 0, 0, -32768, 32767));
        send_poll(mk_poll(1, 16'hFFFF, 32767, -32768, 0, 0));
        send_poll(mk_poll(0, 16'h0000, 0, 0, 32767, 32767));
        send_poll(mk_poll(1, 16'hFFFF, -32768, 32767, 32767, -32768));
        send_poll(mk_poll(1, 16'h0EE0, 8000, -8000, 8000, -8000));
        send_poll(mk_poll(1, 16'h0EE0, 8001, 0, 0, -8001));
        send_poll(mk_poll(1, 16'h5555, 0, 0, 0, 0));
        send_poll(mk_poll(1, 16'hAAAA, 0, -32768, -32768, 0));
        send_poll(mk_poll(1, 16'h0000, 0, 0, 0, 0));
        send_poll(mk_poll(0, 16'hFFFF, 32767, 32767, 32767, 32767));
        repeat (3) send_poll(mk_poll(1, 16'h0001, 0, 0, 32767, -32767));
        send_poll(mk_poll(1, 16'h0000, -8001, 8001, 0, 0));
        send_poll(mk_poll(1, 16'h0000, 0, 0, 0, 0));
    endtask

    task automatic test_register_extremes();
        setting_t sweep [6];
        sweep[0] = mk_setting(0, 4095, 4095, 0, 0, 0, 0);
        sweep[1] = mk_setting(32767, 0, 0, 65535, 65535, 65535, 65535);
        sweep[2] = mk_setting(1, 4095, 1, 65535, 0, 0, 65535);
        sweep[3] = random_setting();
        sweep[4] = random_setting();
        sweep[5] = mk_setting(8000, 256, 256, 16384, 49152, 49152, 32768);
        for (int k = 0; k < 6; k++)
        begin
            apply_setting(sweep[k]);
            repeat (40) send_poll(random_poll());
        end
    endtask

    task automatic test_random_polls();
        for (int k = 0; k < 3; k++)
        begin
            apply_setting(random_setting());
            repeat (50) send_poll(random_poll());
        end
    endtask

    task automatic test_steady_flow();
        settle_block();
        no_gaps = 1'b1;
        repeat (60) send_poll(random_poll());
        settle_block();
        no_gaps = 1'b0;
    endtask

    task automatic test_output_backpressure();
        apply_setting(mk_setting(8000, 256, 256, 16384, 49152, 49152, 32768));
        hold_request = 400;
        for (int k = 0; k < 30; k++)
            send_poll(mk_poll(1, k[0] ? 16'h0000 : 16'hFFFF,
                              k[1] ? 32767 : 0, -20000, 30000, k[0] ? 0 : -30000));
        settle_block();
    endtask

    task automatic report_field(input string what, input int unsigned want,
                                input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
            failures = failures + 1;
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            m_axis_tready = 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_axis_tready = no_gaps || ($urandom_range(99) >= 30);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (touch_q.size() == 0)
            begin
                $display("%0t: unexpected event slot %0d action %0d x %0d y %0d last %0d",
                         $time, m_axis_tuser[3:0], m_axis_tuser[5:4], m_axis_tdata[9:0],
                         m_axis_tdata[19:10], m_axis_tlast);
                failures = failures + 1;
            end
            else
            begin
                head_event = touch_q.pop_front();
                report_field("touch_slot", head_event.slot, m_axis_tuser[3:0]);
                report_field("action", head_event.action, m_axis_tuser[5:4]);
                report_field("pos_x", head_event.px, m_axis_tdata[9:0]);
                report_field("pos_y", head_event.py, m_axis_tdata[19:10]);
                report_field("last", head_event.last, m_axis_tlast);
                events_checked = events_checked + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        live_cfg = mk_setting(8000, 256, 256, 16384, 49152, 49152, 32768);
        prev_buttons = '0;
        move_on = 1'b0;
        aim_on = 1'b0;
        aim_acc_x = '0;
        aim_acc_y = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_polls();
        test_register_extremes();
        test_random_polls();
        test_steady_flow();
        test_output_backpressure();
        settle_block();

        if (touch_q.size() != 0)
        begin
            $display("%0t: %0d expected events never arrived", $time, touch_q.size());
            failures = failures + 1;
        end
        $display("%0d polls sent, %0d touch events checked, %0d register writes",
                 polls_sent, events_checked, reg_writes);
        $display("covered button edges, both sticks, register extremes and a long output stall");
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
